FILE: src/hssd_pkg.sv
// Shared types, constants and lookup functions for the Hall sensor speed decoder.
`default_nettype none

package hssd_pkg;

    // Field widths
    localparam int unsigned CODE_W = 3;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned PP_W   = 7;
    localparam int unsigned RPM_W  = 16;
    localparam int unsigned ANG_W  = 16;
    localparam int unsigned SEC_W  = 3;
    localparam int unsigned DIR_W  = 2;
    localparam int unsigned CNT_W  = 32;

    // rpm = 60e6 / (6 * pp * dt) = 10e6 / (pp * dt); the factor of six cancels
    localparam int unsigned QUO_W  = 24;
    localparam int unsigned PROD_W = PP_W + TIME_W;
    localparam logic [QUO_W-1:0] RPM_NUM = 24'd10000000;
    localparam logic [RPM_W-1:0] RPM_MAX = 16'hFFFF;
    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    // Reset values of the configuration registers
    localparam logic [PP_W-1:0]   PP_RESET      = 7'd7;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd80000;

    // Register addresses (word index taken from paddr[2])
    localparam logic REG_POLE_PAIRS = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    // Rotation direction codes
    localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD     = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV     = 2'd2;

    localparam logic [SEC_W-1:0] SEC_LAST = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic eval;
        logic mul;
        logic div_step;
        logic write_rpm;
        logic load_out;
    } hssd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } hssd_stat_t;

    typedef struct packed {
        logic             ok;
        logic [SEC_W-1:0] idx;
    } hssd_sector_t;

    // Hall code to position in the sequence 1,5,4,6,2,3
    function automatic hssd_sector_t code_to_sector(input logic [CODE_W-1:0] code);
        hssd_sector_t r;
        r.ok  = 1'b1;
        r.idx = 3'd0;
        case (code)
            3'd1:    r.idx = 3'd0;
            3'd5:    r.idx = 3'd1;
            3'd4:    r.idx = 3'd2;
            3'd6:    r.idx = 3'd3;
            3'd2:    r.idx = 3'd4;
            3'd3:    r.idx = 3'd5;
            default: r.ok  = 1'b0;
        endcase
        return r;
    endfunction

    // sector * 65536 / 6
    function automatic logic [ANG_W-1:0] sector_angle(input logic [SEC_W-1:0] s);
        logic [ANG_W-1:0] a;
        case (s)
            3'd0:    a = 16'd0;
            3'd1:    a = 16'd10922;
            3'd2:    a = 16'd21845;
            3'd3:    a = 16'd32768;
            3'd4:    a = 16'd43690;
            3'd5:    a = 16'd54613;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: src/hall_sensor_speed_decoder.sv
// Hall sensor decoder with rpm estimate: top level.
//
// Input stream (s_*): one item per Hall sample carrying the three sensor bits and
// microsecond and millisecond timestamps. Output stream (m_*): exactly one item per
// input item with validity, rpm, electrical angle, sector, direction, edge count and
// the millisecond time of the last accepted edge.
// Configuration is over the APB port: pole pairs at 0x0, stall timeout in us at 0x4;
// write only while the block is idle.
// Steps: a sample that needs no division passes from acceptance through the
// evaluate state to the emit state, which loads the output register.
// An edge with a known previous edge time and a non-zero interval runs a 24-step
// restoring divider (10e6 / (pole_pairs * interval)), one quotient bit per cycle,
// between a multiply step and a write step that saturates the rpm; the next sample
// is taken only after the divider has finished and the item has been emitted.
// One sample is in work at a time; s_tready is high only while idle. A finished
// item sits in the output register, so the next sample is accepted while it waits;
// a stalled receiver holds that sample in its final step until the register frees.
// Reset clears the decoder state and the output valid; the first sample after reset
// is taken as the initial read of the sensors.
`default_nettype none

module hall_sensor_speed_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // s_tdata: hall_bits[2:0], time_us[34:3], time_ms[66:35], zero fill [71:67]
    input  wire logic [71:0]  s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // m_tdata: speed_rpm[15:0], angle_q16[31:16], hall_bits_echo[34:32],
    //          sector_index[37:35], rotation_direction[39:38], edge_total[71:40],
    //          last_edge_time_ms[103:72]
    output logic [103:0]      m_tdata,
    // m_tuser: hall_state_valid
    output logic              m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    hssd_pkg::hssd_cmd_t               cmd;
    hssd_pkg::hssd_stat_t              stat;
    logic [hssd_pkg::PP_W-1:0]         pole_pairs;
    logic [hssd_pkg::TIME_W-1:0]       stall_timeout_us;
    logic [hssd_pkg::RPM_W-1:0]        out_rpm;
    logic [hssd_pkg::ANG_W-1:0]        out_angle;
    logic [hssd_pkg::CODE_W-1:0]       out_code;
    logic [hssd_pkg::SEC_W-1:0]        out_sector;
    logic [hssd_pkg::DIR_W-1:0]        out_dir;
    logic [hssd_pkg::CNT_W-1:0]        out_edges;
    logic [hssd_pkg::TIME_W-1:0]       out_edge_ms;

    hssd_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .pole_pairs       (pole_pairs),
        .stall_timeout_us (stall_timeout_us)
    );

    hssd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hssd_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_code          (s_tdata[2:0]),
        .in_time_us       (s_tdata[34:3]),
        .in_time_ms       (s_tdata[66:35]),
        .pole_pairs       (pole_pairs),
        .stall_timeout_us (stall_timeout_us),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_state_valid  (m_tuser),
        .out_rpm          (out_rpm),
        .out_angle        (out_angle),
        .out_code         (out_code),
        .out_sector       (out_sector),
        .out_dir          (out_dir),
        .out_edges        (out_edges),
        .out_edge_ms      (out_edge_ms)
    );

    // Pack the output item
    assign m_tdata = {out_edge_ms, out_edges, out_dir, out_sector, out_code,
                      out_angle, out_rpm};

endmodule

`default_nettype wire

FILE: src/hssd_regs.sv
// APB configuration registers: pole pairs and stall timeout.
`default_nettype none

module hssd_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [hssd_pkg::PP_W-1:0]         pole_pairs,
    output logic [hssd_pkg::TIME_W-1:0]       stall_timeout_us
);

    logic [hssd_pkg::PP_W-1:0]   pp_reg;
    logic [hssd_pkg::TIME_W-1:0] timeout_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg      <= hssd_pkg::PP_RESET;
            timeout_reg <= hssd_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == hssd_pkg::REG_POLE_PAIRS)
                pp_reg <= pwdata[hssd_pkg::PP_W-1:0];
            else
                timeout_reg <= pwdata;
        end
    end

    // Read mux
    always_comb
    begin
        if (paddr[2] == hssd_pkg::REG_TIMEOUT)
            prdata = timeout_reg;
        else
            prdata = {{(32 - hssd_pkg::PP_W){1'b0}}, pp_reg};
    end

    assign pole_pairs       = pp_reg;
    assign stall_timeout_us = timeout_reg;

endmodule

`default_nettype wire

FILE: src/hssd_ctrl.sv
// Sequencing state machine: accept, evaluate, multiply, divide, write, emit.
`default_nettype none

module hssd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire hssd_pkg::hssd_stat_t stat,
    output hssd_pkg::hssd_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_WRITE,
        ST_EMIT
    } state_t;

    state_t state_reg;

    assign s_tready = (state_reg == ST_IDLE);

    // Commands decoded from the current state
    always_comb
    begin
        cmd           = '0;
        cmd.load_in   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.eval      = (state_reg == ST_EVAL);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.write_rpm = (state_reg == ST_WRITE);
        cmd.load_out  = (state_reg == ST_EMIT) && stat.out_free;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    state_reg <= stat.need_div ? ST_MUL : ST_EMIT;
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (stat.div_last)
                        state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (stat.out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/hssd_dp.sv
// Datapath: sector tracking, edge bookkeeping, rpm divider and output register.
`default_nettype none

module hssd_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hssd_pkg::hssd_cmd_t           cmd,
    output hssd_pkg::hssd_stat_t               stat,
    input  wire logic [hssd_pkg::CODE_W-1:0]   in_code,
    input  wire logic [hssd_pkg::TIME_W-1:0]   in_time_us,
    input  wire logic [hssd_pkg::TIME_W-1:0]   in_time_ms,
    input  wire logic [hssd_pkg::PP_W-1:0]     pole_pairs,
    input  wire logic [hssd_pkg::TIME_W-1:0]   stall_timeout_us,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic                               out_state_valid,
    output logic [hssd_pkg::RPM_W-1:0]         out_rpm,
    output logic [hssd_pkg::ANG_W-1:0]         out_angle,
    output logic [hssd_pkg::CODE_W-1:0]        out_code,
    output logic [hssd_pkg::SEC_W-1:0]         out_sector,
    output logic [hssd_pkg::DIR_W-1:0]         out_dir,
    output logic [hssd_pkg::CNT_W-1:0]         out_edges,
    output logic [hssd_pkg::TIME_W-1:0]        out_edge_ms
);

    // Latched input item
    logic [hssd_pkg::CODE_W-1:0] code_reg;
    logic [hssd_pkg::TIME_W-1:0] now_us_reg;
    logic [hssd_pkg::TIME_W-1:0] now_ms_reg;

    // Decoder state
    logic                        primed_reg;
    logic [hssd_pkg::SEC_W-1:0]  sector_reg;
    logic                        valid_reg;
    logic [hssd_pkg::DIR_W-1:0]  dir_reg;
    logic [hssd_pkg::RPM_W-1:0]  rpm_reg;
    logic [hssd_pkg::ANG_W-1:0]  angle_reg;
    logic [hssd_pkg::CNT_W-1:0]  edges_reg;
    logic [hssd_pkg::TIME_W-1:0] edge_us_reg;
    logic [hssd_pkg::TIME_W-1:0] edge_ms_reg;
    logic [hssd_pkg::CODE_W-1:0] raw_reg;

    // Divider
    logic [hssd_pkg::TIME_W-1:0] dt_reg;
    logic [hssd_pkg::PROD_W-1:0] divisor_reg;
    logic [hssd_pkg::QUO_W-1:0]  num_reg;
    logic [hssd_pkg::QUO_W-1:0]  rem_reg;
    logic [hssd_pkg::QUO_W-1:0]  quo_reg;
    logic [hssd_pkg::STEP_W-1:0] step_reg;

    // Output register
    logic                        out_valid_reg;

    hssd_pkg::hssd_sector_t      look;
    logic [hssd_pkg::SEC_W-1:0]  sec_next_pos;
    logic [hssd_pkg::SEC_W-1:0]  sec_prev_pos;
    logic                        is_fwd;
    logic                        is_rev;
    logic                        have_edge;
    logic [hssd_pkg::TIME_W-1:0] elapsed;
    logic                        stalled;
    logic [hssd_pkg::QUO_W:0]    trial;
    logic                        fits;

    // Evaluation of the latched sample against the current position
    always_comb
    begin
        look         = hssd_pkg::code_to_sector(code_reg);
        sec_next_pos = (sector_reg == hssd_pkg::SEC_LAST) ? '0 : sector_reg + 3'd1;
        sec_prev_pos = (sector_reg == '0) ? hssd_pkg::SEC_LAST : sector_reg - 3'd1;
        is_fwd       = look.ok && (look.idx == sec_next_pos);
        is_rev       = look.ok && (look.idx == sec_prev_pos);
        have_edge    = (edge_us_reg != '0);
        elapsed      = now_us_reg - edge_us_reg;
        stalled      = have_edge && (elapsed > stall_timeout_us);
    end

    // One restoring division step: bring down a numerator bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, num_reg[hssd_pkg::QUO_W-1]};
        fits  = {{(hssd_pkg::PROD_W - hssd_pkg::QUO_W - 1){1'b0}}, trial} >= divisor_reg;
    end

    assign stat.need_div = primed_reg && (is_fwd || is_rev) && have_edge && (elapsed != '0);
    assign stat.div_last = (step_reg == hssd_pkg::LAST_STEP);
    assign stat.out_free = !out_valid_reg || m_tready;

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            code_reg   <= in_code;
            now_us_reg <= in_time_us;
            now_ms_reg <= in_time_ms;
        end
    end

    // Decoder state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg  <= 1'b0;
            sector_reg  <= '0;
            valid_reg   <= 1'b0;
            dir_reg     <= hssd_pkg::DIR_UNKNOWN;
            rpm_reg     <= '0;
            angle_reg   <= '0;
            edges_reg   <= '0;
            edge_us_reg <= '0;
            edge_ms_reg <= '0;
            raw_reg     <= '0;
        end
        else if (cmd.eval)
        begin
            raw_reg <= code_reg;
            if (!primed_reg)
            begin
                // initial read
                primed_reg  <= 1'b1;
                valid_reg   <= look.ok;
                sector_reg  <= look.ok ? look.idx : '0;
                angle_reg   <= look.ok ? hssd_pkg::sector_angle(look.idx) : '0;
                dir_reg     <= hssd_pkg::DIR_UNKNOWN;
                rpm_reg     <= '0;
                edges_reg   <= '0;
                edge_us_reg <= '0;
                edge_ms_reg <= '0;
            end
            else if (!look.ok)
            begin
                valid_reg <= 1'b0;
                if (stalled)
                    rpm_reg <= '0;
            end
            else
            begin
                valid_reg <= 1'b1;
                angle_reg <= hssd_pkg::sector_angle(look.idx);
                if (look.idx == sector_reg)
                begin
                    if (stalled)
                        rpm_reg <= '0;
                end
                else if (is_fwd || is_rev)
                begin
                    // adjacent step: an accepted edge; skipped sectors fall through
                    dir_reg     <= is_fwd ? hssd_pkg::DIR_FWD : hssd_pkg::DIR_REV;
                    sector_reg  <= look.idx;
                    edge_us_reg <= now_us_reg;
                    edge_ms_reg <= now_ms_reg;
                    edges_reg   <= edges_reg + 32'd1;
                end
            end
        end
        else if (cmd.write_rpm)
        begin
            // saturate the quotient to 16 bits
            if (|quo_reg[hssd_pkg::QUO_W-1:hssd_pkg::RPM_W])
                rpm_reg <= hssd_pkg::RPM_MAX;
            else
                rpm_reg <= quo_reg[hssd_pkg::RPM_W-1:0];
        end
    end

    // Divisor build and bit-serial division of 10e6 by pp * dt
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            dt_reg <= elapsed;
        end
        if (cmd.mul)
        begin
            divisor_reg <= hssd_pkg::PROD_W'(pole_pairs) * hssd_pkg::PROD_W'(dt_reg);
            num_reg     <= hssd_pkg::RPM_NUM;
            rem_reg     <= '0;
            quo_reg     <= '0;
            step_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= {num_reg[hssd_pkg::QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[hssd_pkg::QUO_W-2:0], fits};
            step_reg <= step_reg + 5'd1;
            if (fits)
                rem_reg <= hssd_pkg::QUO_W'(trial - hssd_pkg::QUO_W'(divisor_reg));
            else
                rem_reg <= trial[hssd_pkg::QUO_W-1:0];
        end
    end

    // Output item valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_state_valid <= valid_reg;
            out_rpm         <= rpm_reg;
            out_angle       <= angle_reg;
            out_code        <= raw_reg;
            out_sector      <= sector_reg;
            out_dir         <= dir_reg;
            out_edges       <= edges_reg;
            out_edge_ms     <= edge_ms_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the Hall sensor speed decoder: directed and random samples.
`default_nettype none

module tb;

    import hssd_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          REPORT_LIMIT = 10;
    localparam longint unsigned RPM_SCALE = 64'd60000000;

    // One output item, unpacked from the stream
    typedef struct packed {
        logic              valid;
        logic [RPM_W-1:0]  rpm;
        logic [ANG_W-1:0]  angle;
        logic [CODE_W-1:0] echo;
        logic [SEC_W-1:0]  sector;
        logic [DIR_W-1:0]  dir;
        logic [CNT_W-1:0]  edges;
        logic [TIME_W-1:0] last_ms;
    } hall_result_t;

    // Decoder state as the testbench tracks it
    typedef struct packed {
        logic              primed;
        logic [SEC_W-1:0]  sector;
        logic              valid;
        logic [DIR_W-1:0]  dir;
        logic [RPM_W-1:0]  rpm;
        logic [ANG_W-1:0]  angle;
        logic [CNT_W-1:0]  edges;
        logic [TIME_W-1:0] last_us;
        logic [TIME_W-1:0] last_ms;
    } decoder_state_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [71:0]  s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Predicted decoder state and register copies
    decoder_state_t    dec = '0;
    logic [PP_W-1:0]   pole_pairs_cfg = PP_RESET;
    logic [TIME_W-1:0] timeout_cfg = TIMEOUT_RESET;
    hall_result_t      expected_q[$];

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int result_count = 0;
    int cycle_count = 0;

    // Random walk over the sensor sequence
    int                walk_dir = 1;
    logic [TIME_W-1:0] clock_us = 32'h0001_0000;
    logic [TIME_W-1:0] clock_ms = 32'd0;

    hall_sensor_speed_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // Position of a Hall code in the commutation sequence; returns 0 for an illegal code
    function automatic logic hall_position(input logic [CODE_W-1:0] code,
                                           output logic [SEC_W-1:0] pos);
        logic ok;
        ok  = 1'b1;
        pos = '0;
        case (code)
            3'd1:    pos = 3'd0;
            3'd5:    pos = 3'd1;
            3'd4:    pos = 3'd2;
            3'd6:    pos = 3'd3;
            3'd2:    pos = 3'd4;
            3'd3:    pos = 3'd5;
            default: ok  = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [CODE_W-1:0] hall_code_of(input logic [SEC_W-1:0] pos);
        logic [CODE_W-1:0] code;
        case (pos)
            3'd0:    code = 3'd1;
            3'd1:    code = 3'd5;
            3'd2:    code = 3'd4;
            3'd3:    code = 3'd6;
            3'd4:    code = 3'd2;
            default: code = 3'd3;
        endcase
        return code;
    endfunction

    function automatic logic [ANG_W-1:0] sector_q16(input logic [SEC_W-1:0] pos);
        int unsigned a;
        a = (32'(pos) * 32'd65536) / 32'd6;
        return a[ANG_W-1:0];
    endfunction

    // Zero the speed once the last edge is older than the timeout
    function automatic void apply_stall(input logic [TIME_W-1:0] now_us);
        logic [TIME_W-1:0] elapsed;
        elapsed = now_us - dec.last_us;
        if (dec.last_us != 0 && elapsed > timeout_cfg)
            dec.rpm = '0;
    endfunction

    // Advance the decoder state by one sample and return the item it should emit
    function automatic hall_result_t predict_sample(input logic [CODE_W-1:0] code,
                                                    input logic [TIME_W-1:0] now_us,
                                                    input logic [TIME_W-1:0] now_ms);
        logic              ok;
        logic [SEC_W-1:0]  pos;
        int                delta;
        logic [TIME_W-1:0] dt;
        longint unsigned   divisor;
        longint unsigned   quo;
        hall_result_t      r;
        ok = hall_position(code, pos);
        if (!dec.primed)
        begin
            // initial read after reset
            dec.primed  = 1'b1;
            dec.valid   = ok;
            dec.sector  = ok ? pos : '0;
            dec.angle   = ok ? sector_q16(pos) : '0;
            dec.dir     = DIR_UNKNOWN;
            dec.rpm     = '0;
            dec.edges   = '0;
            dec.last_us = '0;
            dec.last_ms = '0;
        end
        else if (!ok)
        begin
            dec.valid = 1'b0;
            apply_stall(now_us);
        end
        else
        begin
            dec.valid = 1'b1;
            dec.angle = sector_q16(pos);
            if (pos == dec.sector)
                apply_stall(now_us);
            else
            begin
                delta = (int'(pos) + 6 - int'(dec.sector)) % 6;
                // only a step to a neighbouring sector counts as an edge
                if (delta == 1 || delta == 5)
                begin
                    if (dec.last_us != 0)
                    begin
                        dt = now_us - dec.last_us;
                        if (dt != 0)
                        begin
                            divisor = 64'd6 * pole_pairs_cfg * dt;
                            quo = (divisor == 0) ? 64'(RPM_MAX) : RPM_SCALE / divisor;
                            dec.rpm = (quo > 64'(RPM_MAX)) ? RPM_MAX : quo[RPM_W-1:0];
                        end
                    end
                    dec.dir     = (delta == 1) ? DIR_FWD : DIR_REV;
                    dec.sector  = pos;
                    dec.last_us = now_us;
                    dec.last_ms = now_ms;
                    dec.edges   = dec.edges + 1;
                end
            end
        end
        r.valid   = dec.valid;
        r.rpm     = dec.rpm;
        r.angle   = dec.angle;
        r.echo    = code;
        r.sector  = dec.sector;
        r.dir     = dec.dir;
        r.edges   = dec.edges;
        r.last_ms = dec.last_ms;
        return r;
    endfunction

    // Offer one sample, wait for it to be taken, then record the expected item
    task automatic send_sample(input logic [CODE_W-1:0] code,
                               input logic [TIME_W-1:0] now_us,
                               input logic [TIME_W-1:0] now_ms);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, now_ms, now_us, code};
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(predict_sample(code, now_us, now_ms));
    endtask

    // Drop the input valid and wait until every expected item has come out
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Write a register over APB while idle, then read it back
    task automatic program_register(input logic reg_sel, input logic [31:0] value);
        logic [31:0] want;
        wait_for_results();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_sel == REG_POLE_PAIRS)
        begin
            pole_pairs_cfg = value[PP_W-1:0];
            want = 32'(value[PP_W-1:0]);
        end
        else
        begin
            timeout_cfg = value;
            want = value;
        end
        // read-back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("register %0d read-back: expected 0x%08h got 0x%08h",
                         reg_sel, want, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One sample from the random walk: mostly neighbouring steps, some noise
    task automatic send_random_sample();
        int                pick;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] dt;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            if ($urandom_range(9) < 2)
                walk_dir = -walk_dir;
            code = hall_code_of(3'((int'(dec.sector) + 6 + walk_dir) % 6));
        end
        else if (pick < 72)
            code = hall_code_of(dec.sector);
        else if (pick < 80)
            code = hall_code_of(3'((int'(dec.sector) + int'($urandom_range(2, 4))) % 6));
        else if (pick < 88)
            code = $urandom_range(1) ? 3'd0 : 3'd7;
        else
            code = 3'($urandom_range(7));
        // time step: mostly short intervals, some long, some wrapping
        dt = '0;
        pick = $urandom_range(99);
        if (pick < 5)
            dt = '0;
        else if (pick < 75)
            dt = $urandom_range(1, 3000);
        else if (pick < 90)
            dt = $urandom_range(3000, 200000);
        else if (pick < 96)
            dt = $urandom;
        clock_us = clock_us + dt;
        if (pick >= 96 && pick < 98)
            clock_us = '0;
        else if (pick >= 98)
            clock_us = 32'hFFFF_FFFF - $urandom_range(0, 40);
        if ($urandom_range(15) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + dt / 1000;
        send_sample(code, clock_us, clock_ms);
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each output item with the oldest expectation
    always @(posedge clk)
    begin : result_check
        hall_result_t got;
        hall_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.valid   = m_tuser;
            got.rpm     = m_tdata[15:0];
            got.angle   = m_tdata[31:16];
            got.echo    = m_tdata[34:32];
            got.sector  = m_tdata[37:35];
            got.dir     = m_tdata[39:38];
            got.edges   = m_tdata[71:40];
            got.last_ms = m_tdata[103:72];
            result_count++;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("item %0d arrived with nothing expected", result_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.valid !== want.valid || got.rpm !== want.rpm
                    || got.angle !== want.angle || got.echo !== want.echo
                    || got.sector !== want.sector || got.dir !== want.dir
                    || got.edges !== want.edges || got.last_ms !== want.last_ms)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("item %0d mismatch", result_count);
                        $display("  expected valid=%0d rpm=%0d angle=%0d code=%0d sector=%0d",
                                 want.valid, want.rpm, want.angle, want.echo, want.sector);
                        $display("           dir=%0d edges=%0d last_ms=%0d",
                                 want.dir, want.edges, want.last_ms);
                        $display("  actual   valid=%0d rpm=%0d angle=%0d code=%0d sector=%0d",
                                 got.valid, got.rpm, got.angle, got.echo, got.sector);
                        $display("           dir=%0d edges=%0d last_ms=%0d",
                                 got.dir, got.edges, got.last_ms);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // First sample after reset is the initial read, here an illegal code
    task automatic test_initial_read();
        send_sample(3'd7, 32'h8000_0001, 32'hFFFF_FFFF);
        send_sample(3'd0, 32'h8000_0002, 32'h0000_0000);
    endtask

    // Edges with no previous edge time, zero interval, reversal, skip, saturation
    task automatic test_edge_timing();
        send_sample(3'd1, 32'd0, 32'd0);
        send_sample(3'd5, 32'd0, 32'hFFFF_FFFF);
        send_sample(3'd4, 32'd1000, 32'd1);
        send_sample(3'd6, 32'd1000, 32'd2);
        send_sample(3'd2, 32'd2000, 32'd3);
        send_sample(3'd6, 32'd2500, 32'd4);
        send_sample(3'd1, 32'd2550, 32'd5);
        send_sample(3'd6, 32'd2600, 32'd6);
        send_sample(3'd2, 32'd2601, 32'd7);
        send_sample(3'd3, 32'd2602, 32'd8);
    endtask

    // Timeout boundary, timeout on an illegal code, edges across the counter wrap
    task automatic test_stall_timeout();
        send_sample(3'd3, 32'd82602, 32'd9);
        send_sample(3'd3, 32'd82603, 32'd10);
        send_sample(3'd2, 32'd90000, 32'd11);
        send_sample(3'd7, 32'd170001, 32'd12);
        send_sample(3'd3, 32'hFFFF_FFF0, 32'd13);
        send_sample(3'd1, 32'h0000_0010, 32'd14);
    endtask

    // Zero pole pairs gives a zero divisor and a saturated speed
    task automatic test_zero_pole_pairs();
        program_register(REG_POLE_PAIRS, 32'd0);
        send_sample(3'd5, 32'h0000_0020, 32'd15);
        send_sample(3'd4, 32'h0000_0030, 32'd16);
        program_register(REG_POLE_PAIRS, 32'(PP_RESET));
    endtask

    // Receiver holds off for a long stretch so the input stalls
    task automatic test_output_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (12)
            send_random_sample();
    endtask

    // Random gaps and stalls; after five samples the sender waits for every item before going on
    task automatic test_sender_pause();
        gap_pct = 24;
        stall_pct = 24;
        repeat (5)
            send_random_sample();
        wait_for_results();
        repeat (5)
            send_random_sample();
    endtask

    // Random rotation under each idling pattern and a range of register settings
    task automatic test_random_rotation();
        int phase;
        int half;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 58; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            for (half = 0; half < 2; half++)
            begin
                case (phase * 2 + half)
                    0:
                    begin
                        program_register(REG_POLE_PAIRS, 32'd1);
                        program_register(REG_TIMEOUT, 32'd1);
                    end
                    1:
                    begin
                        program_register(REG_POLE_PAIRS, 32'd64);
                        program_register(REG_TIMEOUT, 32'hFFFF_FFFF);
                    end
                    2:
                    begin
                        program_register(REG_POLE_PAIRS, 32'd7);
                        program_register(REG_TIMEOUT, 32'd80000);
                    end
                    3:
                    begin
                        program_register(REG_POLE_PAIRS, 32'd127);
                        program_register(REG_TIMEOUT, 32'd2000);
                    end
                    4:
                    begin
                        program_register(REG_POLE_PAIRS, 32'd0);
                        program_register(REG_TIMEOUT, 32'd500);
                    end
                    5:
                    begin
                        program_register(REG_POLE_PAIRS, $urandom_range(1, 64));
                        program_register(REG_TIMEOUT, $urandom_range(1000, 300000));
                    end
                    6:
                    begin
                        program_register(REG_POLE_PAIRS, 32'd2);
                        program_register(REG_TIMEOUT, 32'd100000);
                    end
                    default:
                    begin
                        program_register(REG_POLE_PAIRS, 32'd64);
                        program_register(REG_TIMEOUT, 32'd1);
                    end
                endcase
                repeat (92)
                    send_random_sample();
            end
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_initial_read();
        test_edge_timing();
        test_stall_timeout();
        test_zero_pole_pairs();
        test_output_backpressure();
        test_sender_pause();
        test_random_rotation();

        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
